### hw/rtl/glld_pkg.sv
package glld_pkg;

  // Operand and datapath widths
  localparam int unsigned InW     = 34;  // CORDIC operand width (signed)
  localparam int unsigned RadW    = 68;  // radicand width of the square roots
  localparam int unsigned RootW   = 34;  // root width
  localparam int unsigned SqW     = 66;  // width of one square / one dot term
  localparam int unsigned CrdW    = 64;  // CORDIC x/y width
  localparam int unsigned AngW    = 32;  // angle accumulator, degrees * 2^20
  localparam int unsigned ShW     = 6;   // normalizing shift count
  localparam int unsigned NormMsb = 59;  // normalized magnitude lies in [2^59, 2^60)
  localparam int unsigned DiffW   = 29;  // magnitude of the longitude difference
  localparam int unsigned LatW    = 24;
  localparam int unsigned LonW    = 25;
  localparam int unsigned DistW   = 32;

  // CORDIC lanes
  localparam int unsigned Lanes   = 3;
  localparam int unsigned LaneLat = 0;
  localparam int unsigned LaneLos = 1;
  localparam int unsigned LaneRef = 2;

  // Angles in degrees * 2^20, limits in degrees * 2^16
  localparam logic signed [AngW-1:0] Deg90  = 32'sd94371840;
  localparam logic signed [AngW-1:0] Deg180 = 32'sd188743680;
  localparam logic signed [AngW-1:0] Deg360 = 32'sd377487360;
  localparam logic signed [AngW-1:0] LatMax = 32'sd5898240;
  localparam logic signed [AngW-1:0] LonMax = 32'sd23592960;
  localparam logic signed [AngW-1:0] RndHalf = 32'sd8;

  // round(atan(2^-i) * 180/pi * 2^20)
  function automatic logic signed [AngW-1:0] atan_deg20(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:  r = 32'sd47185920;
      5'd1:  r = 32'sd27855475;
      5'd2:  r = 32'sd14718068;
      5'd3:  r = 32'sd7471121;
      5'd4:  r = 32'sd3750058;
      5'd5:  r = 32'sd1876857;
      5'd6:  r = 32'sd938658;
      5'd7:  r = 32'sd469357;
      5'd8:  r = 32'sd234682;
      5'd9:  r = 32'sd117342;
      5'd10: r = 32'sd58671;
      5'd11: r = 32'sd29335;
      5'd12: r = 32'sd14668;
      5'd13: r = 32'sd7334;
      5'd14: r = 32'sd3667;
      5'd15: r = 32'sd1833;
      5'd16: r = 32'sd917;
      5'd17: r = 32'sd458;
      5'd18: r = 32'sd229;
      5'd19: r = 32'sd115;
      5'd20: r = 32'sd57;
      5'd21: r = 32'sd29;
      5'd22: r = 32'sd14;
      5'd23: r = 32'sd7;
      5'd24: r = 32'sd4;
      5'd25: r = 32'sd2;
      5'd26: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [InW-1:0] dx;
    logic signed [InW-1:0] dy;
    logic signed [InW-1:0] dz;
    logic signed [InW-1:0] cx;
    logic signed [InW-1:0] cy;
    logic                  flip;
    logic                  degen;
  } glld_side_t;

  typedef struct packed {
    logic [RadW-1:0] rho_sq;
    logic [RadW-1:0] dist_sq;
    glld_side_t      side;
  } glld_front_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             flip;
    logic             degen;
  } glld_tail_t;

endpackage

### hw/rtl/glld_if.sv
interface glld_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] star_x;
  logic signed [31:0] star_y;
  logic signed [31:0] star_z;
  logic signed [31:0] sun_x;
  logic signed [31:0] sun_y;
  logic signed [31:0] sun_z;
  logic signed [31:0] sun_vel_x;
  logic signed [31:0] sun_vel_y;

  modport source (
    output valid, star_x, star_y, star_z, sun_x, sun_y, sun_z, sun_vel_x, sun_vel_y,
    input  ready
  );
  modport sink (
    input  valid, star_x, star_y, star_z, sun_x, sun_y, sun_z, sun_vel_x, sun_vel_y,
    output ready
  );
endinterface

interface glld_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] distance;
  logic signed [23:0] latitude_deg;
  logic        [24:0] longitude_deg;
  logic               degenerate;

  modport source (
    output valid, distance, latitude_deg, longitude_deg, degenerate,
    input  ready
  );
  modport sink (
    input  valid, distance, latitude_deg, longitude_deg, degenerate,
    output ready
  );
endinterface

### hw/rtl/glld_front.sv
module glld_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  glld_in_if.sink               in_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output glld_pkg::glld_front_t data_o
);

  localparam int unsigned InW  = glld_pkg::InW;
  localparam int unsigned SqW  = glld_pkg::SqW;
  localparam int unsigned RadW = glld_pkg::RadW;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1: offsets
  logic signed [InW-1:0] dx_q, dy_q, dz_q, cx_q, cy_q;
  logic signed [31:0]    vx_q, vy_q;
  // stage 2: squares and dot terms
  logic [SqW-1:0]        sqx_q, sqy_q, sqz_q;
  logic signed [SqW-1:0] p_q, q_q;
  glld_pkg::glld_side_t  side2_q;
  // stage 3: sums
  glld_pkg::glld_front_t out_q;

  logic [InW-1:0]        mx, my, mz;
  logic [SqW-1:0]        sqx_d, sqy_d, sqz_d;
  logic signed [SqW-1:0] p_d, q_d;
  logic signed [SqW:0]   pq;

  assign en3 = !v3_q || ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    mx = dx_q[InW-1] ? InW'(-dx_q) : InW'(dx_q);
    my = dy_q[InW-1] ? InW'(-dy_q) : InW'(dy_q);
    mz = dz_q[InW-1] ? InW'(-dz_q) : InW'(dz_q);
    sqx_d = mx[32:0] * mx[32:0];
    sqy_d = my[32:0] * my[32:0];
    sqz_d = mz[32:0] * mz[32:0];
    p_d = dx_q * vx_q;
    q_d = dy_q * vy_q;
    pq  = (SqW+1)'(p_q) + (SqW+1)'(q_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      dx_q <= InW'(in_i.star_x) - InW'(in_i.sun_x);
      dy_q <= InW'(in_i.star_y) - InW'(in_i.sun_y);
      dz_q <= InW'(in_i.star_z) - InW'(in_i.sun_z);
      cx_q <= -InW'(in_i.sun_x);
      cy_q <= -InW'(in_i.sun_y);
      vx_q <= in_i.sun_vel_x;
      vy_q <= in_i.sun_vel_y;
    end
    if (en2 && v1_q) begin
      sqx_q         <= sqx_d;
      sqy_q         <= sqy_d;
      sqz_q         <= sqz_d;
      p_q           <= p_d;
      q_q           <= q_d;
      side2_q.dx    <= dx_q;
      side2_q.dy    <= dy_q;
      side2_q.dz    <= dz_q;
      side2_q.cx    <= cx_q;
      side2_q.cy    <= cy_q;
      side2_q.flip  <= 1'b0;
      side2_q.degen <= 1'b0;
    end
    if (en3 && v2_q) begin
      out_q.rho_sq  <= RadW'(sqx_q) + RadW'(sqy_q);
      out_q.dist_sq <= RadW'(sqx_q) + RadW'(sqy_q) + RadW'(sqz_q);
      out_q.side    <= '{dx:    side2_q.dx,
                         dy:    side2_q.dy,
                         dz:    side2_q.dz,
                         cx:    side2_q.cx,
                         cy:    side2_q.cy,
                         flip:  pq[SqW],
                         degen: (side2_q.dx == '0) && (side2_q.dy == '0)};
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

### hw/rtl/glld_sqrt.sv
module glld_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [glld_pkg::RadW-1:0]   rad_a_i,
  input  logic [glld_pkg::RadW-1:0]   rad_b_i,
  input  glld_pkg::glld_side_t        side_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [glld_pkg::RootW-1:0]  root_a_o,
  output logic [glld_pkg::RootW-1:0]  root_b_o,
  output glld_pkg::glld_side_t        side_o
);

  localparam int unsigned N    = glld_pkg::RootW;
  localparam int unsigned RadW = glld_pkg::RadW;
  localparam int unsigned RemW = N + 2;

  logic [N-1:0]         v_q, en;
  logic [RadW-1:0]      rad_q  [N][2];
  logic [RemW-1:0]      rem_q  [N][2];
  logic [N-1:0]         root_q [N][2];
  glld_pkg::glld_side_t side_q [N];

  // one root bit per stage, two radicands side by side
  for (genvar k = 0; k < N; k++) begin : g_st
    logic                 pv, nrdy;
    logic [RadW-1:0]      prad  [2];
    logic [RemW-1:0]      prem  [2];
    logic [N-1:0]         proot [2];
    glld_pkg::glld_side_t pside;

    if (k == N-1) begin : g_last
      assign nrdy = ready_i;
    end else begin : g_mid
      assign nrdy = en[k+1];
    end
    assign en[k] = !v_q[k] || nrdy;

    if (k == 0) begin : g_first
      assign pv       = valid_i;
      assign prad[0]  = rad_a_i;
      assign prad[1]  = rad_b_i;
      assign prem[0]  = '0;
      assign prem[1]  = '0;
      assign proot[0] = '0;
      assign proot[1] = '0;
      assign pside    = side_i;
    end else begin : g_next
      assign pv       = v_q[k-1];
      assign prad[0]  = rad_q[k-1][0];
      assign prad[1]  = rad_q[k-1][1];
      assign prem[0]  = rem_q[k-1][0];
      assign prem[1]  = rem_q[k-1][1];
      assign proot[0] = root_q[k-1][0];
      assign proot[1] = root_q[k-1][1];
      assign pside    = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && pv) side_q[k] <= pside;
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RemW-1:0] rem_sh, trial;
      logic            ge;

      always_comb begin
        rem_sh = {prem[l][RemW-3:0], prad[l][RadW-1 -: 2]};
        trial  = {proot[l], 2'b01};
        ge     = rem_sh >= trial;
      end

      always_ff @(posedge clk_i) begin
        if (en[k] && pv) begin
          rad_q[k][l]  <= {prad[l][RadW-3:0], 2'b00};
          rem_q[k][l]  <= ge ? rem_sh - trial : rem_sh;
          root_q[k][l] <= {proot[l][N-2:0], ge};
        end
      end
    end
  end

  assign ready_o  = en[0];
  assign valid_o  = v_q[N-1];
  assign root_a_o = root_q[N-1][0];
  assign root_b_o = root_q[N-1][1];
  assign side_o   = side_q[N-1];

endmodule

### hw/rtl/glld_cordic.sv
module glld_cordic #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [glld_pkg::InW-1:0]   x_i [glld_pkg::Lanes],
  input  logic signed [glld_pkg::InW-1:0]   y_i [glld_pkg::Lanes],
  input  glld_pkg::glld_tail_t              tail_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [glld_pkg::AngW-1:0]  ang_o [glld_pkg::Lanes],
  output glld_pkg::glld_tail_t              tail_o
);

  localparam int unsigned InW   = glld_pkg::InW;
  localparam int unsigned CrdW  = glld_pkg::CrdW;
  localparam int unsigned AngW  = glld_pkg::AngW;
  localparam int unsigned ShW   = glld_pkg::ShW;
  localparam int unsigned Lanes = glld_pkg::Lanes;
  localparam int unsigned NSt   = CORDIC_STAGES + 2;

  logic [NSt-1:0]       v_q, en;
  logic [Lanes-1:0]     z_q    [NSt];
  glld_pkg::glld_tail_t tail_q [NSt];

  // normalize stage
  logic signed [InW-1:0] nx_q [Lanes];
  logic signed [InW-1:0] ny_q [Lanes];
  logic [ShW-1:0]        ns_q [Lanes];

  // prerotation and micro-rotation stages
  logic signed [CrdW-1:0] x_q [NSt-1][Lanes];
  logic signed [CrdW-1:0] y_q [NSt-1][Lanes];
  logic signed [AngW-1:0] a_q [NSt-1][Lanes];

  for (genvar j = 0; j < NSt; j++) begin : g_st
    logic                 pv, nrdy;
    logic [Lanes-1:0]     pz;
    glld_pkg::glld_tail_t pt;

    if (j == NSt-1) begin : g_last
      assign nrdy = ready_i;
    end else begin : g_mid
      assign nrdy = en[j+1];
    end
    assign en[j] = !v_q[j] || nrdy;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j] && pv) begin
        z_q[j]    <= pz;
        tail_q[j] <= pt;
      end
    end

    if (j == 0) begin : g_norm
      assign pv = valid_i;
      assign pt = tail_i;
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        logic [InW-1:0] mx, my, mm;
        logic [ShW-1:0] pos;

        // locate the leading one of the larger magnitude
        always_comb begin
          mx  = x_i[l][InW-1] ? InW'(-x_i[l]) : InW'(x_i[l]);
          my  = y_i[l][InW-1] ? InW'(-y_i[l]) : InW'(y_i[l]);
          mm  = (mx > my) ? mx : my;
          pos = '0;
          for (int b = 0; b < InW; b++) begin
            if (mm[b]) pos = ShW'(b);
          end
        end
        assign pz[l] = (mm == '0);

        always_ff @(posedge clk_i) begin
          if (en[j] && pv) begin
            nx_q[l] <= x_i[l];
            ny_q[l] <= y_i[l];
            ns_q[l] <= ShW'(glld_pkg::NormMsb) - pos;
          end
        end
      end
    end else if (j == 1) begin : g_pre
      assign pv = v_q[0];
      assign pt = tail_q[0];
      assign pz = z_q[0];
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        logic signed [CrdW-1:0] xw, yw, xr, yr;
        logic signed [AngW-1:0] ar;

        // shift up, then fold the left half plane by a quarter turn
        always_comb begin
          xw = CrdW'(nx_q[l]) <<< ns_q[l];
          yw = CrdW'(ny_q[l]) <<< ns_q[l];
          if (xw[CrdW-1]) begin
            if (!yw[CrdW-1]) begin
              xr = yw;
              yr = -xw;
              ar = glld_pkg::Deg90;
            end else begin
              xr = -yw;
              yr = xw;
              ar = -glld_pkg::Deg90;
            end
          end else begin
            xr = xw;
            yr = yw;
            ar = '0;
          end
        end

        always_ff @(posedge clk_i) begin
          if (en[j] && pv) begin
            x_q[0][l] <= xr;
            y_q[0][l] <= yr;
            a_q[0][l] <= ar;
          end
        end
      end
    end else begin : g_iter
      localparam int unsigned Sh = j - 2;
      assign pv = v_q[j-1];
      assign pt = tail_q[j-1];
      assign pz = z_q[j-1];
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        logic signed [CrdW-1:0] xs, ys;

        assign xs = x_q[j-2][l] >>> Sh;
        assign ys = y_q[j-2][l] >>> Sh;

        always_ff @(posedge clk_i) begin
          if (en[j] && pv) begin
            if (!y_q[j-2][l][CrdW-1]) begin
              x_q[j-1][l] <= x_q[j-2][l] + ys;
              y_q[j-1][l] <= y_q[j-2][l] - xs;
              a_q[j-1][l] <= a_q[j-2][l] + glld_pkg::atan_deg20(5'(Sh));
            end else begin
              x_q[j-1][l] <= x_q[j-2][l] - ys;
              y_q[j-1][l] <= y_q[j-2][l] + xs;
              a_q[j-1][l] <= a_q[j-2][l] - glld_pkg::atan_deg20(5'(Sh));
            end
          end
        end
      end
    end
  end

  // a zero vector has angle zero
  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign ang_o[l] = z_q[NSt-1][l] ? '0 : a_q[NSt-2][l];
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NSt-1];
  assign tail_o  = tail_q[NSt-1];

endmodule

### hw/rtl/glld_back.sv
module glld_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [glld_pkg::AngW-1:0]  ang_i [glld_pkg::Lanes],
  input  glld_pkg::glld_tail_t              tail_i,
  glld_out_if.source                        out_o
);

  localparam int unsigned AngW  = glld_pkg::AngW;
  localparam int unsigned DiffW = glld_pkg::DiffW;
  localparam int unsigned LatW  = glld_pkg::LatW;
  localparam int unsigned LonW  = glld_pkg::LonW;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic signed [LatW-1:0] lat1_q, lat2_q, lat_q;
  logic signed [AngW:0]   diff1_q;
  logic [DiffW-1:0]       diff2_q;
  glld_pkg::glld_tail_t   tail1_q, tail2_q;
  logic [31:0]            dist_q;
  logic [LonW-1:0]        lon_q;
  logic                   degen_q;

  logic signed [AngW-1:0] lr, lc, t, lo;
  logic signed [AngW:0]   w;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    // latitude: round to 2^-16 degrees, clamp to +-90
    lr = (ang_i[glld_pkg::LaneLat] + glld_pkg::RndHalf) >>> 4;
    if (lr > glld_pkg::LatMax) begin
      lc = glld_pkg::LatMax;
    end else if (lr < -glld_pkg::LatMax) begin
      lc = -glld_pkg::LatMax;
    end else begin
      lc = lr;
    end
    // wrap the difference into [-180, 180]
    if (diff1_q > (AngW+1)'(glld_pkg::Deg180)) begin
      w = diff1_q - (AngW+1)'(glld_pkg::Deg360);
    end else if (diff1_q < -(AngW+1)'(glld_pkg::Deg180)) begin
      w = diff1_q + (AngW+1)'(glld_pkg::Deg360);
    end else begin
      w = diff1_q;
    end
    // mirror when moving away, then round and clamp; zero when degenerate
    t  = tail2_q.flip ? glld_pkg::Deg360 - AngW'(diff2_q) : AngW'(diff2_q);
    lo = (t + glld_pkg::RndHalf) >>> 4;
    if (lo > glld_pkg::LonMax) lo = glld_pkg::LonMax;
    if (lo < 0) lo = '0;
    if (tail2_q.degen) lo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      lat1_q  <= LatW'(lc);
      diff1_q <= (AngW+1)'(ang_i[glld_pkg::LaneLos]) - (AngW+1)'(ang_i[glld_pkg::LaneRef]);
      tail1_q <= tail_i;
    end
    if (en2 && v1_q) begin
      lat2_q  <= lat1_q;
      diff2_q <= w[AngW] ? DiffW'(-w) : DiffW'(w);
      tail2_q <= tail1_q;
    end
    if (en3 && v2_q) begin
      lat_q   <= lat2_q;
      lon_q   <= LonW'(lo);
      dist_q  <= tail2_q.distance;
      degen_q <= tail2_q.degen;
    end
  end

  assign out_o.valid         = v3_q;
  assign out_o.distance      = dist_q;
  assign out_o.latitude_deg  = lat_q;
  assign out_o.longitude_deg = lon_q;
  assign out_o.degenerate    = degen_q;

endmodule

### hw/rtl/galactic_longitude_latitude_distance_core.sv
// Pipeline from input transaction to result:
//   3 offset/square/sum stages, 34 square root stages, CORDIC_STAGES + 2 CORDIC stages,
//   3 angle combine and output stages.
// Throughput: one transaction per cycle unless stalled; stages hold valid bits, fill bubbles.
// Reset (rst_ni low, asynchronous) clears all valid bits; the datapath holds no other state.
module galactic_longitude_latitude_distance_core #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  glld_in_if.sink    in_i,
  glld_out_if.source out_o
);

  localparam int unsigned InW   = glld_pkg::InW;
  localparam int unsigned RootW = glld_pkg::RootW;
  localparam int unsigned AngW  = glld_pkg::AngW;
  localparam int unsigned Lanes = glld_pkg::Lanes;

  // front end: offsets, squares, sums, sign of the velocity dot product
  logic                  fr_valid, fr_ready;
  glld_pkg::glld_front_t fr_data;

  glld_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  // floor roots of the in-plane and full squared lengths
  logic                 sq_valid, sq_ready;
  logic [RootW-1:0]     rho, dist_root;
  glld_pkg::glld_side_t sq_side;

  glld_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fr_valid),
    .ready_o  (fr_ready),
    .rad_a_i  (fr_data.rho_sq),
    .rad_b_i  (fr_data.dist_sq),
    .side_i   (fr_data.side),
    .valid_o  (sq_valid),
    .ready_i  (sq_ready),
    .root_a_o (rho),
    .root_b_o (dist_root),
    .side_o   (sq_side)
  );

  // three vectoring CORDIC lanes: latitude, line of sight, direction to the center
  logic signed [InW-1:0]  cx [Lanes];
  logic signed [InW-1:0]  cy [Lanes];
  glld_pkg::glld_tail_t   c_tail;
  logic                   cr_valid, cr_ready;
  logic signed [AngW-1:0] ang [Lanes];
  glld_pkg::glld_tail_t   cr_tail;

  always_comb begin
    cx[glld_pkg::LaneLat] = InW'(rho);
    cy[glld_pkg::LaneLat] = sq_side.dz;
    cx[glld_pkg::LaneLos] = sq_side.dx;
    cy[glld_pkg::LaneLos] = sq_side.dy;
    cx[glld_pkg::LaneRef] = sq_side.cx;
    cy[glld_pkg::LaneRef] = sq_side.cy;
    // saturate the distance to Q16.16
    c_tail.distance = (dist_root[RootW-1:32] != '0) ? '1 : dist_root[31:0];
    c_tail.flip     = sq_side.flip;
    c_tail.degen    = sq_side.degen;
  end

  glld_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .x_i     (cx),
    .y_i     (cy),
    .tail_i  (c_tail),
    .valid_o (cr_valid),
    .ready_i (cr_ready),
    .ang_o   (ang),
    .tail_o  (cr_tail)
  );

  // angle difference, mirror, rounding, output register
  glld_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_valid),
    .ready_o (cr_ready),
    .ang_i   (ang),
    .tail_i  (cr_tail),
    .out_o   (out_o)
  );

  a_degen_lon_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |-> out_o.longitude_deg == '0)
    else $error("degenerate transaction with nonzero longitude");

  a_zero_dist_degen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.distance == '0) |-> out_o.degenerate && (out_o.latitude_deg == '0))
    else $error("zero distance without degenerate flag or with nonzero latitude");

  a_lat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.latitude_deg <= 24'sd5898240) && (out_o.latitude_deg >= -24'sd5898240))
    else $error("latitude out of range");

  a_lon_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.longitude_deg <= 25'd23592960)
    else $error("longitude out of range");

endmodule

### tb/galactic_longitude_latitude_distance_core_checker.sv
`timescale 1ns / 100ps

module galactic_longitude_latitude_distance_core_checker #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  glld_in_if   in_i,
  glld_out_if  out_i,
  output int   mismatch_count_o,
  output int   coords_pending_o
);

  localparam longint Deg180Q20 = 64'sd188743680;
  localparam longint Deg360Q20 = 64'sd377487360;
  localparam longint LatLimit  = 64'sd5898240;
  localparam longint LonLimit  = 64'sd23592960;
  localparam longint NormFloor = 64'sd576460752303423488;  // 2^59

  // atan(2^-i) in degrees * 2^20
  localparam longint AtanStep [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [31:0]        distance;
    logic signed [23:0] latitude_deg;
    logic [24:0]        longitude_deg;
    logic               degenerate;
  } galactic_coords_t;

  galactic_coords_t pending_coords[$];
  int               mismatches;
  int               pending_count;

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      trial = 128'(root | (64'd1 << b));
      if (trial * trial <= n) root = root | (64'd1 << b);
    end
    return root;
  endfunction

  // Vectoring CORDIC, result in degrees * 2^20
  function automatic longint cordic_angle(longint y, longint x);
    longint ang;
    longint m;
    longint t;
    longint xs;
    longint ys;
    int     sh;
    ang = 0;
    sh  = 0;
    if (x == 0 && y == 0) return 0;
    m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
    while (m < NormFloor) begin
      m = m <<< 1;
      sh++;
    end
    x = x <<< sh;
    y = y <<< sh;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = Deg180Q20 / 2;
      end else begin
        t = x; x = -y; y = t; ang = -Deg180Q20 / 2;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang += AtanStep[i];
      end else begin
        x = x - ys; y = y + xs; ang -= AtanStep[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_to_q16(longint a);
    return (a + 8) >>> 4;
  endfunction

  function automatic galactic_coords_t predict_coords(
      longint sx, longint sy, longint sz, longint ox, longint oy, longint oz,
      longint vx, longint vy);
    galactic_coords_t r;
    longint dx, dy, dz, rho, lat, lon, diff;
    logic [127:0] plane_sq, full_sq;
    logic [63:0] full_root;
    logic signed [127:0] p, q;
    dx = sx - ox;
    dy = sy - oy;
    dz = sz - oz;
    plane_sq = 128'($signed(128'(dx)) * $signed(128'(dx)))
             + 128'($signed(128'(dy)) * $signed(128'(dy)));
    full_sq  = plane_sq + 128'($signed(128'(dz)) * $signed(128'(dz)));
    rho  = longint'(floor_sqrt(plane_sq));
    full_root = floor_sqrt(full_sq);
    r.distance   = (full_root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : full_root[31:0];
    r.degenerate = (dx == 0 && dy == 0);
    if (r.degenerate && dz == 0) begin
      lat = 0;
    end else begin
      lat = round_to_q16(cordic_angle(dz, rho));
      if (lat > LatLimit) lat = LatLimit;
      if (lat < -LatLimit) lat = -LatLimit;
    end
    if (r.degenerate) begin
      lon = 0;
    end else begin
      // angle from the sun-to-center direction, mirrored against the motion
      diff = cordic_angle(dy, dx) - cordic_angle(-oy, -ox);
      p = $signed(128'(dx)) * $signed(128'(vx));
      q = $signed(128'(dy)) * $signed(128'(vy));
      if (diff > Deg180Q20) diff -= Deg360Q20;
      if (diff < -Deg180Q20) diff += Deg360Q20;
      if (diff < 0) diff = -diff;
      if (p < -q) diff = Deg360Q20 - diff;
      lon = round_to_q16(diff);
      if (lon > LonLimit) lon = LonLimit;
      if (lon < 0) lon = 0;
    end
    r.latitude_deg  = lat[23:0];
    r.longitude_deg = lon[24:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    galactic_coords_t want;
    if (!rst_ni) begin
      pending_coords.delete();
      mismatches    = 0;
      pending_count = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        pending_coords.push_back(predict_coords(
            longint'(in_i.star_x), longint'(in_i.star_y), longint'(in_i.star_z),
            longint'(in_i.sun_x), longint'(in_i.sun_y), longint'(in_i.sun_z),
            longint'(in_i.sun_vel_x), longint'(in_i.sun_vel_y)));
      end
      if (out_i.valid && out_i.ready) begin
        if (pending_coords.size() == 0) begin
          $display("%0t: unexpected result dist=%h lat=%h lon=%h degen=%b", $time,
                   out_i.distance, out_i.latitude_deg, out_i.longitude_deg,
                   out_i.degenerate);
          mismatches++;
        end else begin
          want = pending_coords.pop_front();
          if (out_i.distance !== want.distance) begin
            $display("%0t: distance expected %h actual %h", $time, want.distance,
                     out_i.distance);
            mismatches++;
          end
          if (out_i.latitude_deg !== want.latitude_deg) begin
            $display("%0t: latitude expected %h actual %h", $time, want.latitude_deg,
                     out_i.latitude_deg);
            mismatches++;
          end
          if (out_i.longitude_deg !== want.longitude_deg) begin
            $display("%0t: longitude expected %h actual %h", $time, want.longitude_deg,
                     out_i.longitude_deg);
            mismatches++;
          end
          if (out_i.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                     out_i.degenerate);
            mismatches++;
          end
        end
      end
      pending_count = pending_coords.size();
    end
  end

  assign mismatch_count_o = mismatches;
  assign coords_pending_o = pending_count;

endmodule

### tb/galactic_longitude_latitude_distance_core_tb.sv
`timescale 1ns / 100ps

module galactic_longitude_latitude_distance_core_tb;

  localparam int Kpc          = 65536;
  localparam int RandomStars  = 1030;
  localparam int StallLimit   = 3000;  // cycles with no transaction before giving up
  localparam int LongHoldOff  = 500;   // receiver stall, far longer than the pipeline
  localparam int DrainCycles  = 100;   // more than the pipeline depth

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   coords_pending;
  int   quiet_cycles;
  int   results_taken;

  glld_in_if  star_ch ();
  glld_out_if coord_ch ();

  galactic_longitude_latitude_distance_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (star_ch),
    .out_o  (coord_ch)
  );

  galactic_longitude_latitude_distance_core_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (star_ch),
    .out_i            (coord_ch),
    .mismatch_count_o (mismatch_count),
    .coords_pending_o (coords_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Drive everything to known values, hold reset, then release it.
  initial begin
    rst_ni          <= 1'b0;
    star_ch.valid   <= 1'b0;
    star_ch.star_x  <= '0;
    star_ch.star_y  <= '0;
    star_ch.star_z  <= '0;
    star_ch.sun_x   <= '0;
    star_ch.sun_y   <= '0;
    star_ch.sun_z   <= '0;
    star_ch.sun_vel_x <= '0;
    star_ch.sun_vel_y <= '0;
    coord_ch.ready  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Signed value in [-r, r]
  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Offer one star; a zero gap keeps valid high straight into the next transaction.
  task automatic send_star(input int sx, input int sy, input int sz, input int ox,
                           input int oy, input int oz, input int vx, input int vy,
                           input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      star_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    star_ch.valid     <= 1'b1;
    star_ch.star_x    <= sx;
    star_ch.star_y    <= sy;
    star_ch.star_z    <= sz;
    star_ch.sun_x     <= ox;
    star_ch.sun_y     <= oy;
    star_ch.sun_z     <= oz;
    star_ch.sun_vel_x <= vx;
    star_ch.sun_vel_y <= vy;
    do @(posedge clk_i); while (!star_ch.ready);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off that fills the pipe.
  initial begin
    int  gap;
    bit  quiet;
    bit  held;
    quiet = 1'b0;
    held  = 1'b0;
    results_taken = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) quiet = ~quiet;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (!held && results_taken >= 300) begin
        held = 1'b1;
        gap  = LongHoldOff;
      end
      if (gap > 0) begin
        coord_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      coord_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!coord_ch.valid);
      results_taken++;
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (star_ch.valid && star_ch.ready) || (coord_ch.valid && coord_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("galactic_longitude_latitude_distance_core test failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int  kind;
    bit  quiet;
    int  ox, oy;
    @(posedge clk_i iff rst_ni);

    // zero distance, at the origin and elsewhere
    send_star(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_star(123456, -654321, 77777, 123456, -654321, 77777, 5, -5, 0);
    // zero in-plane offset, star straight above and below the observer
    send_star(-8 * Kpc, 0, 3 * Kpc, -8 * Kpc, 0, 0, 0, Kpc, 0);
    send_star(-8 * Kpc, 0, -3 * Kpc, -8 * Kpc, 0, 0, 0, Kpc, 0);
    // observer at the center in-plane
    send_star(2 * Kpc, 3 * Kpc, Kpc, 0, 0, 5 * Kpc, Kpc, 0, 0);
    send_star(-2 * Kpc, -3 * Kpc, 0, 0, 0, 0, 0, -Kpc, 0);
    // field extremes, distance saturation
    send_star(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_star(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_star(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
              32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_star(-1, -1, -1, 0, 0, 0, -1, -1, 0);
    // around a sun at (-8.5, 0): toward, away, along and against the motion
    send_star(0, 0, 0, -557056, 0, 0, 0, 15 * Kpc, 0);
    send_star(-16 * Kpc, 0, 0, -557056, 0, 0, 0, 15 * Kpc, 0);
    send_star(-557056, 4 * Kpc, 0, -557056, 0, 0, 0, 15 * Kpc, 0);
    send_star(-557056, -4 * Kpc, 0, -557056, 0, 0, 0, 15 * Kpc, 0);
    send_star(-7 * Kpc, -Kpc, 2 * Kpc, -557056, 0, 0, 0, 15 * Kpc, 0);
    send_star(-10 * Kpc, Kpc, -2 * Kpc, -557056, 0, 0, 0, -15 * Kpc, 0);
    // velocity orthogonal to the offset: dot product exactly zero
    send_star(Kpc, 0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0);
    // latitude near the poles and on the plane
    send_star(1, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 1, 0, 0);
    send_star(0, 1, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, -1, 0);
    send_star(5 * Kpc, 5 * Kpc, 0, 0, 0, 0, -Kpc, Kpc, 0);

    quiet = 1'b0;
    for (int n = 0; n < RandomStars; n++) begin
      if ($urandom_range(0, 63) == 0) quiet = ~quiet;
      kind = $urandom_range(0, 99);
      ox = spread(10 * Kpc);
      oy = spread(10 * Kpc);
      if (kind < 15) begin
        // raw bit patterns over the full range
        send_star($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, quiet);
      end else if (kind < 85) begin
        // galaxy-scale positions
        send_star(spread(30 * Kpc), spread(30 * Kpc), spread(5 * Kpc), ox, oy,
                  spread(Kpc / 10), spread(300 * Kpc), spread(300 * Kpc), quiet);
      end else if (kind < 92) begin
        // star close to the observer
        send_star(ox + spread(16), oy + spread(16), spread(64), ox, oy, spread(64),
                  spread(Kpc), spread(Kpc), quiet);
      end else if (kind < 96) begin
        // no in-plane offset
        send_star(ox, oy, spread(Kpc), ox, oy, spread(Kpc), spread(Kpc), spread(Kpc), quiet);
      end else begin
        // observer at the center in-plane
        send_star(spread(20 * Kpc), spread(20 * Kpc), spread(Kpc), 0, 0, spread(Kpc),
                  spread(Kpc), spread(Kpc), quiet);
      end
    end
    star_ch.valid <= 1'b0;

    while (coords_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("galactic_longitude_latitude_distance_core test passed");
    end else begin
      $display("galactic_longitude_latitude_distance_core test failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/glld_pkg.sv
hw/rtl/glld_if.sv
hw/rtl/glld_front.sv
hw/rtl/glld_sqrt.sv
hw/rtl/glld_cordic.sv
hw/rtl/glld_back.sv
hw/rtl/galactic_longitude_latitude_distance_core.sv
tb/galactic_longitude_latitude_distance_core_checker.sv
tb/galactic_longitude_latitude_distance_core_tb.sv
